// ===== design/phre_pkg.sv =====
// ----------------------------------------------------------------------------
// phre_pkg: shared types and constants of the pulse heart rate estimator
// field widths, register indexes, reset values and controller/datapath structs
// ----------------------------------------------------------------------------
package phre_pkg;

	localparam int SAMPLE_W  = 12;
	localparam int COUNT_W   = 8;
	localparam int TICK_W    = 16;
	localparam int PERIOD_W  = 8;
	localparam int RATE_W    = 10;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 10;
	localparam int QUOT_W    = 16;
	localparam int DIV_STEPS = 16;
	localparam int STEP_W    = 4;

	localparam logic [QUOT_W-1:0]    MS_PER_MINUTE = 16'd60000;

	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_HIGH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_LOW      = 2'd2;

	localparam logic [PERIOD_W-1:0]  PERIOD_RESET   = 8'd15;
	localparam logic [RATE_W-1:0]    RATE_HI_RESET  = 10'd200;
	localparam logic [RATE_W-1:0]    RATE_LO_RESET  = 10'd30;
	localparam logic [SAMPLE_W-1:0]  WIN_MIN_RESET  = 12'd4095;
	localparam logic [SAMPLE_W-1:0]  JUMP_RESET     = 12'd1024;

	typedef struct packed {
		logic load_sample;
		logic close_window;
		logic cross_eval;
		logic mul_en;
		logic div_start;
		logic load_out;
	} phre_cmd_t;

	typedef struct packed {
		logic hit;
		logic div_busy;
		logic div_done;
	} phre_stat_t;

endpackage

// ===== design/phre_div.sv =====
// ----------------------------------------------------------------------------
// phre_div: iterative restoring divider
// divides the constant ms-per-minute by a 16-bit interval, one bit per cycle
// ----------------------------------------------------------------------------
module phre_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [phre_pkg::QUOT_W-1:0] divisor,
	output logic                        busy,
	output logic                        done,
	output logic [phre_pkg::QUOT_W-1:0] quotient
);
	import phre_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [QUOT_W-1:0] div_q;
	logic [QUOT_W-1:0] rem_q;
	logic [QUOT_W-1:0] quo_q;
	logic [QUOT_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[QUOT_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= MS_PER_MINUTE;
		end else if (busy_q) begin
			// the remainder stays below the divisor, so 16 bits hold it
			rem_q <= fits ? QUOT_W'(trial - {1'b0, div_q}) : trial[QUOT_W-1:0];
			quo_q <= {quo_q[QUOT_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== design/phre_dp.sv =====
// ----------------------------------------------------------------------------
// phre_dp: estimator datapath
// window statistics, crossing detection, interval multiply, divide and clamp
// ----------------------------------------------------------------------------
module phre_dp #(
	parameter int WINDOW_LEN = 66
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [phre_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [phre_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic [phre_pkg::SAMPLE_W-1:0]  sample,
	input  phre_pkg::phre_cmd_t            cmd,
	output phre_pkg::phre_stat_t           stat,
	output logic [phre_pkg::RATE_W-1:0]    heart_rate
);
	import phre_pkg::*;

	localparam logic [COUNT_W-1:0] WIN_LEN = COUNT_W'(WINDOW_LEN);

	logic [PERIOD_W-1:0] period_q;
	logic [RATE_W-1:0]   rate_hi_q;
	logic [RATE_W-1:0]   rate_lo_q;

	logic [SAMPLE_W-1:0] prev_q;
	logic [SAMPLE_W-1:0] samp_q;
	logic [COUNT_W-1:0]  win_cnt_q;
	logic [SAMPLE_W-1:0] win_max_q;
	logic [SAMPLE_W-1:0] win_min_q;
	logic [SAMPLE_W-1:0] mid_q;
	logic [SAMPLE_W-1:0] jump_q;
	logic                above_q;
	logic                parity_q;
	logic [TICK_W-1:0]   tick_q;
	logic [TICK_W-1:0]   first_q;
	logic [TICK_W-1:0]   ticks_q;
	logic [QUOT_W-1:0]   interval_q;
	logic [RATE_W-1:0]   rate_q;

	logic [SAMPLE_W+1:0] diff;
	logic                accept;
	logic [SAMPLE_W:0]   mm_sum;
	logic [SAMPLE_W-1:0] mm_diff;
	logic                above_n;
	logic                rise;
	logic                later;
	logic [PERIOD_W+TICK_W-1:0] product;
	logic                div_busy;
	logic                div_done;
	logic [QUOT_W-1:0]   quotient;
	logic [QUOT_W-1:0]   bpm;
	logic [RATE_W-1:0]   capped;
	logic [RATE_W-1:0]   clamped;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= PERIOD_RESET;
			rate_hi_q <= RATE_HI_RESET;
			rate_lo_q <= RATE_LO_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SAMPLE_PERIOD: period_q  <= cfg_data[PERIOD_W-1:0];
				CFG_RATE_HIGH:     rate_hi_q <= cfg_data[RATE_W-1:0];
				CFG_RATE_LOW:      rate_lo_q <= cfg_data[RATE_W-1:0];
				default:           ;
			endcase
		end
	end

	// signed difference against the previous raw sample
	assign diff    = {2'b00, sample} - {2'b00, prev_q};
	assign accept  = $signed(diff) < $signed({2'b00, jump_q});
	assign mm_sum  = {1'b0, win_max_q} + {1'b0, win_min_q};
	assign mm_diff = win_max_q - win_min_q;
	assign above_n = samp_q > mid_q;
	assign rise    = !above_q && above_n;
	assign later   = first_q < tick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '0;
			win_cnt_q <= '0;
			win_max_q <= '0;
			win_min_q <= WIN_MIN_RESET;
			mid_q     <= '0;
			jump_q    <= JUMP_RESET;
			above_q   <= 1'b0;
			parity_q  <= 1'b0;
			tick_q    <= '0;
			first_q   <= '0;
		end else begin
			if (cmd.load_sample) begin
				prev_q <= sample;
				if (accept) begin
					if (sample > win_max_q) win_max_q <= sample;
					if (sample < win_min_q) win_min_q <= sample;
					win_cnt_q <= win_cnt_q + 1'b1;
				end
			end
			if (cmd.close_window && (win_cnt_q >= WIN_LEN)) begin
				mid_q     <= mm_sum[SAMPLE_W:1];
				jump_q    <= (win_max_q >= win_min_q) ? {1'b0, mm_diff[SAMPLE_W-1:1]} : '0;
				win_cnt_q <= '0;
				win_max_q <= '0;
				win_min_q <= WIN_MIN_RESET;
			end
			if (cmd.cross_eval) begin
				above_q <= above_n;
				if (rise) begin
					parity_q <= !parity_q;
					if (!parity_q) begin
						first_q <= tick_q;
						tick_q  <= tick_q + 1'b1;
					end else begin
						// second crossing restarts the tick count
						tick_q <= later ? '0 : TICK_W'(1);
					end
				end else begin
					tick_q <= tick_q + 1'b1;
				end
			end
		end
	end

	assign product = ticks_q * period_q;

	always_ff @(posedge clk) begin
		if (cmd.load_sample) samp_q <= sample;
		if (cmd.cross_eval) ticks_q <= tick_q - first_q;
		if (cmd.mul_en) interval_q <= product[QUOT_W-1:0];
		if (cmd.load_out) rate_q <= clamped;
	end

	phre_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.divisor  (interval_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quotient)
	);

	// a zero interval reports the high limit
	always_comb begin
		bpm     = (interval_q == '0) ? {{(QUOT_W-RATE_W){1'b0}}, rate_hi_q} : quotient;
		capped  = (bpm > {{(QUOT_W-RATE_W){1'b0}}, rate_hi_q}) ? rate_hi_q : bpm[RATE_W-1:0];
		clamped = (capped < rate_lo_q) ? rate_lo_q : capped;
	end

	assign stat.hit      = cmd.cross_eval && rise && parity_q && later;
	assign stat.div_busy = div_busy;
	assign stat.div_done = div_done;
	assign heart_rate    = rate_q;

endmodule

// ===== design/phre_ctrl.sv =====
// ----------------------------------------------------------------------------
// phre_ctrl: estimator controller
// sequences one sample through the datapath and owns the result handshake
// ----------------------------------------------------------------------------
module phre_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  phre_pkg::phre_stat_t stat,
	output phre_pkg::phre_cmd_t  cmd
);
	import phre_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WIN   = 3'd1;
	localparam logic [2:0] S_CROSS = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_DGO   = 3'd4;
	localparam logic [2:0] S_DWAIT = 3'd5;
	localparam logic [2:0] S_LOAD  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_n;
	logic       out_valid_q;
	logic       out_free;

	// the output register may be refilled in the cycle its transaction completes
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_sample = in_valid;
				if (in_valid) state_n = S_WIN;
			end
			S_WIN: begin
				cmd.close_window = 1'b1;
				state_n = S_CROSS;
			end
			S_CROSS: begin
				cmd.cross_eval = 1'b1;
				state_n = stat.hit ? S_MUL : S_IDLE;
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				state_n = S_DGO;
			end
			S_DGO: begin
				cmd.div_start = 1'b1;
				state_n = S_DWAIT;
			end
			S_DWAIT: begin
				if (stat.div_done) state_n = S_LOAD;
			end
			S_LOAD: begin
				cmd.load_out = out_free;
				if (out_free) state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== design/pulse_heart_rate_estimator_core.sv =====
// ----------------------------------------------------------------------------
// pulse_heart_rate_estimator_core: ppg threshold-crossing heart rate estimator
// each sample passes the window and crossing states; one that ends a beat
// interval also passes multiply, divide and result load; one sample at a time
// reset: arst_n resets control, window and config registers, not data; no clearing pass
// ----------------------------------------------------------------------------
module pulse_heart_rate_estimator_core #(
	parameter int WINDOW_LEN = 66
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [phre_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [phre_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [phre_pkg::SAMPLE_W-1:0]  sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [phre_pkg::RATE_W-1:0]    heart_rate
);
	import phre_pkg::*;

	phre_cmd_t  cmd;
	phre_stat_t stat;

	phre_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	phre_dp #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample     (sample),
		.cmd        (cmd),
		.stat       (stat),
		.heart_rate (heart_rate)
	);

`ifndef SYNTH
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample transaction accepted while a sample is in work");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || out_ready))
		else $error("result register loaded over a pending transaction");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !stat.div_busy)
		else $error("divider started while busy");
`endif

endmodule
